// File: rtl/decimal_digit_trie_engine_top_assert.svh
// Assertion macros for the trie engine top level.
`ifndef DECIMAL_DIGIT_TRIE_ENGINE_TOP_ASSERT_SVH
`define DECIMAL_DIGIT_TRIE_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define DDT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trie engine assertion failed");
`define DDT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trie engine assertion failed");
`else
`define DDT_ASSERT_IMP(label, ante, cons)
`define DDT_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/ddt_pkg.sv
// Shared types and constants for the decimal digit trie engine.
package ddt_pkg;

  localparam int MAX_KEY_DIGITS = 14;
  localparam int RADIX          = 10;
  localparam int DIGIT_W        = 4;
  localparam int KEY_W          = 56;
  localparam int LEN_W          = 4;
  localparam int LANE_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int NODES_USED_W   = 13;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   key_digits;
    logic [LEN_W-1:0]   key_length;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic [NODES_USED_W-1:0] nodes_used;
  } res_t;

  typedef struct packed {
    logic load;
    logic shift;
  } key_ctrl_t;

  typedef struct packed {
    logic              en;
    logic              clear;
    logic [LANE_W-1:0] lane;
  } mem_wr_ctrl_t;

endpackage

// File: rtl/ddt_key_sr.sv
// Key shift register: presents one BCD nibble per cycle while shift is asserted, first digit first.
module ddt_key_sr (
  input  logic                     clk,
  input  logic                     rst,
  input  ddt_pkg::key_ctrl_t       ctrl,
  input  logic [ddt_pkg::KEY_W-1:0] key_digits,
  input  logic [ddt_pkg::LEN_W-1:0] count,
  output logic [ddt_pkg::DIGIT_W-1:0] digit,
  output logic                     last
);
  import ddt_pkg::*;

  logic [KEY_W-1:0] key;
  logic [LEN_W-1:0] remaining;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= key_digits;
    end else if (ctrl.shift) begin
      key <= {key[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (ctrl.load) begin
      remaining <= count;
    end else if (ctrl.shift && (remaining != '0)) begin
      remaining <= remaining - 1'b1;
    end
  end

  assign digit = key[KEY_W-1 -: DIGIT_W];
  assign last  = (remaining == LEN_W'(1));

endmodule

// File: rtl/ddt_child_mem.sv
// Child pointer memory: one row of ten child slots per trie node.
module ddt_child_mem #(
  parameter int NODE_COUNT = 4096,
  parameter int NW         = 12
) (
  input  logic                                  clk,
  input  ddt_pkg::mem_wr_ctrl_t                 wr,
  input  logic [NW-1:0]                         waddr,
  input  logic [NW-1:0]                         wdata,
  input  logic [NW-1:0]                         raddr,
  output logic [ddt_pkg::RADIX-1:0][NW-1:0]     rdata
);
  import ddt_pkg::*;

  logic [RADIX-1:0][NW-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.clear) begin
        mem[waddr] <= '0;
      end else begin
        mem[waddr][wr.lane] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/decimal_digit_trie_engine_top.sv
// Top level of the decimal digit trie engine: request control and walk sequencer.
//
// Usage:
//   A request (req, req_valid/req_stall) carries an insert or a lookup of up to
//   fourteen BCD nibbles. Each request yields exactly one result on res
//   (res_valid/res_stall): found, status and the count of nodes in use.
//   The walk handles one key nibble per cycle through the child memory, whose
//   registered read of node N's row overlaps the decision on the previous one.
//   A request walks one key nibble per step in S_WALK and then enters the
//   finish step S_DONE, where the result is registered; an empty insert or an
//   invalid lookup length goes straight to the finish step. An insert stops
//   early when the node pool runs out. One request is in flight at a time: a
//   new request is taken only after the previous one has left the finish step.
//   After reset the block clears the child memory one row per cycle, and
//   req_stall stays high meanwhile. The result sits in an output register: a
//   stalled result holds, and the next request may be accepted and walked
//   while it waits. The finish step waits only if the previous result has
//   still not been taken.
module decimal_digit_trie_engine_top #(
  parameter int NODE_COUNT    = 4096,
  parameter int LOOKUP_DIGITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ddt_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output ddt_pkg::res_t res
);
  import ddt_pkg::*;

  `include "decimal_digit_trie_engine_top_assert.svh"

  localparam int NW = $clog2(NODE_COUNT);
  localparam int FW = $clog2(NODE_COUNT + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WALK, S_DONE} state_t;

  state_t state, state_next;
  logic [NW-1:0] clr_addr;
  logic [NW-1:0] node, node_next;
  logic [FW-1:0] free_node, free_node_next;
  logic is_lookup, is_lookup_next;
  logic miss, miss_next;
  logic bad, bad_next;
  logic full, full_next;

  key_ctrl_t             kctl;
  mem_wr_ctrl_t          wr_ctrl;
  logic [NW-1:0]         waddr, wdata, raddr;
  logic [RADIX-1:0][NW-1:0] rdata;
  logic [DIGIT_W-1:0]    digit;
  logic                  last;
  logic [LEN_W-1:0]      len_sat;
  logic                  len_ok;
  logic                  is_digit;
  logic [NW-1:0]         child;
  logic                  has_child;
  logic                  pool_full;
  logic                  req_accept;
  logic                  res_load;
  logic                  alloc_wr;

  ddt_key_sr u_key_sr (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (kctl),
    .key_digits (req.key_digits),
    .count      (len_sat),
    .digit      (digit),
    .last       (last)
  );

  ddt_child_mem #(
    .NODE_COUNT (NODE_COUNT),
    .NW         (NW)
  ) u_child_mem (
    .clk   (clk),
    .wr    (wr_ctrl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign res_load   = (state == S_DONE) && (!res_valid || !res_stall);

  assign len_sat = (req.key_length > LEN_W'(MAX_KEY_DIGITS)) ?
                   LEN_W'(MAX_KEY_DIGITS) : req.key_length;
  assign len_ok  = ({1'b0, req.key_length} == 5'(LOOKUP_DIGITS)) &&
                   (req.key_length <= LEN_W'(MAX_KEY_DIGITS));

  assign is_digit  = (digit <= DIGIT_MAX);
  assign child     = is_digit ? rdata[digit] : '0;
  assign has_child = (child != '0);
  assign pool_full = (free_node >= FW'(NODE_COUNT));
  assign alloc_wr  = wr_ctrl.en && !wr_ctrl.clear;

  // The read address follows the node chosen this cycle, so the row of the
  // current node is always waiting in rdata during the walk.
  assign raddr = node_next;

  always_comb begin
    state_next     = state;
    node_next      = node;
    free_node_next = free_node;
    is_lookup_next = is_lookup;
    miss_next      = miss;
    bad_next       = bad;
    full_next      = full;
    kctl           = '0;
    wr_ctrl        = '0;
    waddr          = node;
    wdata          = free_node[NW-1:0];
    unique case (state)
      S_CLEAR: begin
        wr_ctrl.en    = 1'b1;
        wr_ctrl.clear = 1'b1;
        waddr         = clr_addr;
        if (clr_addr == NW'(NODE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_accept) begin
          kctl.load      = 1'b1;
          node_next      = '0;
          is_lookup_next = (req.req_type == REQ_LOOKUP);
          miss_next      = 1'b0;
          full_next      = 1'b0;
          bad_next       = (req.req_type == REQ_LOOKUP) && !len_ok;
          if (((req.req_type == REQ_LOOKUP) && !len_ok) || (len_sat == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        kctl.shift = 1'b1;
        if (last) begin
          state_next = S_DONE;
        end
        if (is_lookup) begin
          // A missing path still scans the rest for non-digits.
          if (!is_digit) begin
            bad_next = 1'b1;
          end else if (!miss) begin
            if (has_child) begin
              node_next = child;
            end else begin
              miss_next = 1'b1;
            end
          end
        end else if (is_digit) begin
          if (has_child) begin
            node_next = child;
          end else if (pool_full) begin
            full_next  = 1'b1;
            state_next = S_DONE;
          end else begin
            wr_ctrl.en     = 1'b1;
            wr_ctrl.lane   = digit;
            node_next      = free_node[NW-1:0];
            free_node_next = free_node + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      node      <= '0;
      free_node <= FW'(1);
      is_lookup <= 1'b0;
      miss      <= 1'b0;
      bad       <= 1'b0;
      full      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      node      <= node_next;
      free_node <= free_node_next;
      is_lookup <= is_lookup_next;
      miss      <= miss_next;
      bad       <= bad_next;
      full      <= full_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (res_load) begin
      res.found      <= is_lookup && !bad && !miss;
      res.status     <= bad ? STATUS_INVALID : (full ? STATUS_FULL : STATUS_OK);
      res.nodes_used <= NODES_USED_W'(free_node);
    end
  end

  `DDT_ASSERT_IMP(a_free_range, 1'b1, (free_node != '0) && (free_node <= FW'(NODE_COUNT)))
  `DDT_ASSERT_NXT(a_alloc_step, 1'b1, (free_node - $past(free_node)) <= FW'(1))
  `DDT_ASSERT_IMP(a_write_insert, alloc_wr, (state == S_WALK) && !is_lookup && (waddr != raddr))

endmodule
